>>> sv/lpd_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the length-prefixed deframer
package lpd_pkg;

	// event codes reported on the result channel
	typedef logic [2:0] kind_t;
	localparam kind_t EV_PAYLOAD  = 3'd0;
	localparam kind_t EV_EMPTY    = 3'd1;
	localparam kind_t EV_MISMATCH = 3'd2;
	localparam kind_t EV_ZERO     = 3'd3;
	localparam kind_t EV_PING     = 3'd4;

	// configuration register indexes (byte address = 8 * index)
	localparam logic REG_PING_MARKER    = 1'b0;
	localparam logic REG_START_SEQUENCE = 1'b1;

	localparam int APB_DATA_W = 64;
	localparam int APB_ADDR_W = 4;

	// configuration seen by the frame engine
	typedef struct packed {
		logic [63:0] ping_marker;
		logic        seq_load;
		logic [7:0]  seq_value;
	} cfg_t;

	// one result item
	typedef struct packed {
		kind_t      event_kind;
		logic [7:0] data_byte;
		logic       frame_last;
		logic [7:0] sequence_seen;
	} result_t;

endpackage

>>> sv/lpd_rx_if.sv
`timescale 1ns / 1ps
// receive byte channel interface
interface lpd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

>>> sv/lpd_ev_if.sv
`timescale 1ns / 1ps
// event result channel interface
interface lpd_ev_if;
	logic                valid;
	logic                ready;
	lpd_pkg::kind_t      event_kind;
	logic [7:0]          data_byte;
	logic                frame_last;
	logic [7:0]          sequence_seen;

	modport source (output valid, output event_kind, output data_byte,
		output frame_last, output sequence_seen, input ready);
	modport sink (input valid, input event_kind, input data_byte,
		input frame_last, input sequence_seen, output ready);
endinterface

>>> sv/lpd_cfg.sv
`timescale 1ns / 1ps
// apb configuration registers for the deframer
module lpd_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lpd_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [lpd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [lpd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output lpd_pkg::cfg_t                   cfg
);
	import lpd_pkg::*;

	logic [63:0] ping_marker_q;
	logic [7:0]  start_sequence_q;
	logic        wr_en;
	logic        reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	// registers sit on 8-byte strides, low address bits are ignored
	assign reg_sel = paddr[3];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ping_marker_q    <= '1;
			start_sequence_q <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_PING_MARKER:    ping_marker_q    <= pwdata;
				REG_START_SEQUENCE: start_sequence_q <= pwdata[7:0];
				default:            ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_sel)
			REG_PING_MARKER:    prdata = ping_marker_q;
			REG_START_SEQUENCE: prdata = {56'd0, start_sequence_q};
			default:            prdata = '0;
		endcase
	end

	// a start_sequence write also reloads the expected sequence
	assign cfg.ping_marker = ping_marker_q;
	assign cfg.seq_load    = wr_en && (reg_sel == REG_START_SEQUENCE);
	assign cfg.seq_value   = pwdata[7:0];

endmodule

>>> sv/lpd_core.sv
`timescale 1ns / 1ps
// frame state machine: header assembly, sequence check, body countdown
module lpd_core #(
	parameter int LENGTH_BYTES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lpd_pkg::cfg_t     cfg,
	input  logic              fire,
	input  logic [7:0]        byte_in,
	output logic              res_valid,
	output lpd_pkg::result_t  res
);
	import lpd_pkg::*;

	localparam int LEN_W = 8 * LENGTH_BYTES;
	localparam int IDX_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LENGTH_BYTES - 1);

	localparam logic [1:0] PH_LENGTH  = 2'd0;
	localparam logic [1:0] PH_SEQ     = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;
	localparam logic [1:0] PH_DISCARD = 2'd3;

	logic [1:0]       phase_q, phase_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [LEN_W-1:0] accum_q;
	logic [LEN_W-1:0] left_q, left_d;
	logic [7:0]       fseq_q, fseq_d;
	logic [7:0]       exp_q, exp_d;
	logic [LEN_W-1:0] len_full;
	logic [LEN_W-1:0] left_dec;
	logic             left_zero;

	// header value with the byte now arriving in the top lane
	always_comb begin
		len_full = accum_q;
		len_full[LEN_W-1 -: 8] = byte_in;
	end

	assign left_dec  = left_q - LEN_W'(1);
	assign left_zero = (left_dec == '0);

	// next state and result
	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		left_d    = left_q;
		fseq_d    = fseq_q;
		exp_d     = exp_q;
		res_valid = 1'b0;
		res       = '0;
		case (phase_q)
			PH_LENGTH: begin
				if (idx_q != IDX_LAST) begin
					idx_d = idx_q + IDX_W'(1);
				end else begin
					idx_d = '0;
					if (64'(len_full) == cfg.ping_marker) begin
						res_valid      = 1'b1;
						res.event_kind = EV_PING;
					end else if (len_full == '0) begin
						res_valid      = 1'b1;
						res.event_kind = EV_ZERO;
					end else begin
						left_d  = len_full;
						phase_d = PH_SEQ;
					end
				end
			end
			PH_SEQ: begin
				fseq_d            = byte_in;
				left_d            = left_dec;
				res.sequence_seen = byte_in;
				if (byte_in == exp_q) begin
					exp_d = exp_q + 8'd1;
					if (left_zero) begin
						phase_d        = PH_LENGTH;
						res_valid      = 1'b1;
						res.event_kind = EV_EMPTY;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end else if (left_zero) begin
					phase_d        = PH_LENGTH;
					res_valid      = 1'b1;
					res.event_kind = EV_MISMATCH;
				end else begin
					phase_d = PH_DISCARD;
				end
			end
			PH_PAYLOAD: begin
				left_d            = left_dec;
				res_valid         = 1'b1;
				res.event_kind    = EV_PAYLOAD;
				res.data_byte     = byte_in;
				res.frame_last    = left_zero;
				res.sequence_seen = fseq_q;
				if (left_zero) begin
					phase_d = PH_LENGTH;
				end
			end
			default: begin
				left_d            = left_dec;
				res.sequence_seen = fseq_q;
				if (left_zero) begin
					phase_d        = PH_LENGTH;
					res_valid      = 1'b1;
					res.event_kind = EV_MISMATCH;
				end
			end
		endcase
		res_valid = res_valid && fire;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LENGTH;
			idx_q   <= '0;
			left_q  <= '0;
			fseq_q  <= '0;
			exp_q   <= '0;
		end else begin
			if (fire) begin
				phase_q <= phase_d;
				idx_q   <= idx_d;
				left_q  <= left_d;
				fseq_q  <= fseq_d;
			end
			if (cfg.seq_load) begin
				exp_q <= cfg.seq_value;
			end else if (fire) begin
				exp_q <= exp_d;
			end
		end
	end

	// header lanes, each written once per header before use
	always_ff @(posedge clk) begin
		if (fire && (phase_q == PH_LENGTH)) begin
			for (int j = 0; j < LENGTH_BYTES; j++) begin
				if (idx_q == IDX_W'(j)) begin
					accum_q[8*j +: 8] <= byte_in;
				end
			end
		end
	end

endmodule

>>> sv/length_prefixed_deframer.sv
`timescale 1ns / 1ps
// Length-prefixed deframer with sequence check. Takes one received byte per
// transfer and sustains one byte per clock unless the event output stalls; an
// event is presented after its byte passes the input register and then the
// event register. The per-byte frame update is one header-width decrement and
// compare. A waiting event still lets the empty input register fill. Each
// frame opens with a LENGTH_BYTES little-endian length; a length equal to
// ping_marker is reported as a ping, a zero length as a drop, otherwise the
// first body byte is checked against the expected sequence number and the
// remaining bytes are delivered (last one flagged) or the body is dropped.
// Registers: ping_marker at byte address 0, start_sequence at 8 (writing it
// reloads the expected sequence). Write configuration only while idle.
module length_prefixed_deframer #(
	parameter int LENGTH_BYTES = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	lpd_rx_if.sink                          rx,
	lpd_ev_if.source                        ev,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lpd_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [lpd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [lpd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import lpd_pkg::*;

	cfg_t       cfg;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv;
	logic       fire;
	logic       res_valid;
	result_t    res;
	logic       ev_valid_q;
	result_t    ev_q;

	lpd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// stage 1 moves on when the event register is free or being drained
	assign adv      = !ev_valid_q || ev.ready;
	assign fire     = valid_s1 && adv;
	assign rx.ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	lpd_core #(
		.LENGTH_BYTES (LENGTH_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.fire      (fire),
		.byte_in   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_q <= 1'b0;
		end else if (adv) begin
			ev_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			ev_q <= res;
		end
	end

	assign ev.valid         = ev_valid_q;
	assign ev.event_kind    = ev_q.event_kind;
	assign ev.data_byte     = ev_q.data_byte;
	assign ev.frame_last    = ev_q.frame_last;
	assign ev.sequence_seen = ev_q.sequence_seen;

endmodule

>>> sv/lpd_checker.sv
`timescale 1ns / 1ps
// port-level checks for the deframer, bound to the top level
module lpd_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   ev_valid,
	input  logic                   ev_ready,
	input  lpd_pkg::kind_t         event_kind,
	input  logic [7:0]             data_byte,
	input  logic                   frame_last,
	input  logic [7:0]             sequence_seen
);
	import lpd_pkg::*;

	// a stalled event keeps its contents
	a_ev_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && !ev_ready |=> ev_valid && $stable(event_kind) && $stable(data_byte)
			&& $stable(frame_last) && $stable(sequence_seen))
		else $error("event changed while stalled");

	// only the defined event codes leave the block
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid |-> event_kind <= EV_PING)
		else $error("undefined event code");

	// data and last flag belong to payload bytes only
	a_non_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && event_kind != EV_PAYLOAD |-> data_byte == 8'd0 && !frame_last)
		else $error("data or last flag on a non-payload event");

	// header-level events carry no sequence number
	a_header_seq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && (event_kind == EV_ZERO || event_kind == EV_PING)
			|-> sequence_seen == 8'd0)
		else $error("sequence on a ping or zero length event");

endmodule

bind length_prefixed_deframer lpd_checker u_lpd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.ev_valid      (ev.valid),
	.ev_ready      (ev.ready),
	.event_kind    (ev.event_kind),
	.data_byte     (ev.data_byte),
	.frame_last    (ev.frame_last),
	.sequence_seen (ev.sequence_seen)
);

>>> tb/lpd_event_checker.sv
`timescale 1ns / 1ps
// event checker for the deframer: follows bytes and register writes, compares events
module lpd_event_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	lpd_rx_if                              rx,
	lpd_ev_if                              ev,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lpd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [lpd_pkg::APB_DATA_W-1:0] pwdata,
	input  logic                           pready,
	output int                             mismatch_count,
	output int                             events_pending
);
	import lpd_pkg::*;

	localparam int HEADER_BYTES = 8;
	localparam logic [APB_ADDR_W-1:0] ADDR_PING_MARKER    = {REG_PING_MARKER, 3'b000};
	localparam logic [APB_ADDR_W-1:0] ADDR_START_SEQUENCE = {REG_START_SEQUENCE, 3'b000};

	typedef enum logic [1:0] {
		FR_LENGTH,
		FR_SEQUENCE,
		FR_PAYLOAD,
		FR_DISCARD
	} frame_phase_t;

	// shadow of the deframer state and its registers
	frame_phase_t  phase;
	int            header_count;
	logic [63:0]   length_acc;
	logic [63:0]   body_left;
	logic [63:0]   ping_marker;
	logic [7:0]    frame_seq;
	logic [7:0]    seq_wanted;
	logic [7:0]    in_byte;

	result_t       expected_events[$];
	result_t       want;
	result_t       new_event;
	logic          has_event;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase          = FR_LENGTH;
			header_count   = 0;
			length_acc     = '0;
			body_left      = '0;
			ping_marker    = '1;
			frame_seq      = '0;
			seq_wanted     = '0;
			mismatch_count = 0;
			expected_events.delete();
			events_pending = 0;
		end else begin
			// compare an event transfer with the oldest prediction
			if (ev.valid && ev.ready) begin
				if (expected_events.size() == 0) begin
					$error({"unexpected event: event_kind %0d data_byte %0d",
						" frame_last %0d sequence_seen %0d"},
						ev.event_kind, ev.data_byte, ev.frame_last, ev.sequence_seen);
					mismatch_count++;
				end else begin
					want = expected_events.pop_front();
					if (ev.event_kind !== want.event_kind) begin
						$error("event_kind expected %0d actual %0d",
							want.event_kind, ev.event_kind);
						mismatch_count++;
					end
					if (ev.data_byte !== want.data_byte) begin
						$error("data_byte expected %0d actual %0d",
							want.data_byte, ev.data_byte);
						mismatch_count++;
					end
					if (ev.frame_last !== want.frame_last) begin
						$error("frame_last expected %0d actual %0d",
							want.frame_last, ev.frame_last);
						mismatch_count++;
					end
					if (ev.sequence_seen !== want.sequence_seen) begin
						$error("sequence_seen expected %0d actual %0d",
							want.sequence_seen, ev.sequence_seen);
						mismatch_count++;
					end
				end
			end

			// advance the frame state on a byte transfer
			if (rx.valid && rx.ready) begin
				in_byte   = rx.rx_byte;
				has_event = 1'b0;
				new_event = '0;
				case (phase)
					FR_LENGTH: begin
						length_acc = length_acc | (64'(in_byte) << (8 * header_count));
						header_count++;
						if (header_count == HEADER_BYTES) begin
							header_count = 0;
							// ping takes precedence over a zero length
							if (length_acc == ping_marker) begin
								has_event            = 1'b1;
								new_event.event_kind = EV_PING;
							end else if (length_acc == '0) begin
								has_event            = 1'b1;
								new_event.event_kind = EV_ZERO;
							end else begin
								body_left = length_acc;
								phase     = FR_SEQUENCE;
							end
							length_acc = '0;
						end
					end
					FR_SEQUENCE: begin
						frame_seq = in_byte;
						body_left--;
						if (in_byte == seq_wanted) begin
							seq_wanted++;
							if (body_left == '0) begin
								phase                   = FR_LENGTH;
								has_event               = 1'b1;
								new_event.event_kind    = EV_EMPTY;
								new_event.sequence_seen = frame_seq;
							end else begin
								phase = FR_PAYLOAD;
							end
						end else if (body_left == '0) begin
							phase                   = FR_LENGTH;
							has_event               = 1'b1;
							new_event.event_kind    = EV_MISMATCH;
							new_event.sequence_seen = frame_seq;
						end else begin
							phase = FR_DISCARD;
						end
					end
					FR_PAYLOAD: begin
						body_left--;
						has_event               = 1'b1;
						new_event.event_kind    = EV_PAYLOAD;
						new_event.data_byte     = in_byte;
						new_event.frame_last    = (body_left == '0);
						new_event.sequence_seen = frame_seq;
						if (body_left == '0)
							phase = FR_LENGTH;
					end
					default: begin
						// mismatched body is swallowed, one drop on its last byte
						body_left--;
						if (body_left == '0) begin
							phase                   = FR_LENGTH;
							has_event               = 1'b1;
							new_event.event_kind    = EV_MISMATCH;
							new_event.sequence_seen = frame_seq;
						end
					end
				endcase
				if (has_event)
					expected_events.insert(expected_events.size(), new_event);
			end

			// register writes, to be made only while the block is idle; the checker does not enforce this
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_PING_MARKER)
					ping_marker = pwdata;
				else if (paddr == ADDR_START_SEQUENCE)
					seq_wanted = pwdata[7:0];
			end

			events_pending = expected_events.size();
		end
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// top of the deframer testbench: clock, reset, byte and register stimulus, event sink and verdict
module testbench;
	import lpd_pkg::*;

	localparam logic [APB_ADDR_W-1:0] ADDR_PING_MARKER    = {REG_PING_MARKER, 3'b000};
	localparam logic [APB_ADDR_W-1:0] ADDR_START_SEQUENCE = {REG_START_SEQUENCE, 3'b000};

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	int                    mismatch_count;
	int                    events_pending;

	lpd_rx_if rx_ch();
	lpd_ev_if ev_ch();

	length_prefixed_deframer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.ev      (ev_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	lpd_event_checker event_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx             (rx_ch),
		.ev             (ev_ch),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.mismatch_count (mismatch_count),
		.events_pending (events_pending)
	);

	// stimulus view of the block: marker and next sequence to send
	logic [63:0] cur_marker;
	logic [7:0]  next_seq;
	int          bytes_sent;
	bit          tx_no_gap;
	bit          ev_no_stall;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// one byte transfer, preceded by a random gap
	task automatic put_byte(input logic [7:0] value);
		int gap;
		gap = tx_no_gap ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= value;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		bytes_sent++;
	endtask

	// little-endian length header
	task automatic send_header(input logic [63:0] len);
		for (int i = 0; i < 8; i++)
			put_byte(len[8*i +: 8]);
	endtask

	// header plus body; a length that is a ping or zero carries no body
	task automatic send_frame(input int body_len, input bit seq_ok);
		logic [7:0] seq_byte;
		send_header(64'(body_len));
		if (body_len == 0 || 64'(body_len) == cur_marker)
			return;
		seq_byte = seq_ok ? next_seq : next_seq + 8'($urandom_range(1, 255));
		if (seq_ok)
			next_seq++;
		put_byte(seq_byte);
		repeat (body_len - 1) put_byte(8'($urandom));
	endtask

	// mostly good frames, with pings, zero lengths and sequence errors mixed in
	task automatic random_traffic(input int count);
		int stop_at;
		int pick;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 10)
				send_header(cur_marker);
			else if (pick < 15)
				send_frame(0, 1'b1);
			else if (pick < 27)
				send_frame($urandom_range(1, 8), 1'b0);
			else if (pick < 35)
				send_frame($urandom_range(9, 40), 1'b1);
			else
				send_frame($urandom_range(1, 8), 1'b1);
		end
	endtask

	// drain: all events in, then room for bytes that raise no event
	task automatic settle();
		rx_ch.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (events_pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [63:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [63:0] marker, input logic [7:0] start_seq);
		write_reg(ADDR_PING_MARKER, marker);
		write_reg(ADDR_START_SEQUENCE, 64'(start_seq));
		cur_marker = marker;
		next_seq   = start_seq;
	endtask

	// event sink with random stalls and one long hold-off
	initial begin
		int gap;
		int taken;
		taken = 0;
		ev_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			gap = ev_no_stall ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				ev_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			ev_ch.ready <= 1'b1;
			@(posedge clk);
			while (!ev_ch.valid) @(posedge clk);
			taken++;
			// long hold-off so the byte path backs up
			if (taken == 40) begin
				ev_ch.ready <= 1'b0;
				repeat (80) @(posedge clk);
			end
		end
	end

	// stimulus and verdict
	initial begin
		arst_n        <= 1'b0;
		rx_ch.valid   <= 1'b0;
		rx_ch.rx_byte <= '0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		cur_marker  = '1;
		next_seq    = '0;
		bytes_sent  = 0;
		tx_no_gap   = 1'b0;
		ev_no_stall = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: ping, zero length, short and mismatched bodies
		send_header('1);
		send_frame(0, 1'b1);
		send_frame(1, 1'b1);
		send_frame(1, 1'b0);
		send_frame(3, 1'b1);
		send_frame(4, 1'b0);
		settle();

		// zero marker makes a zero header a ping; sequence wraps from 255
		configure(64'd0, 8'hFF);
		send_frame(0, 1'b1);
		send_frame(1, 1'b1);
		send_frame(2, 1'b1);
		random_traffic(80);
		settle();

		// small marker turns length-3 frames into pings
		configure(64'd3, 8'($urandom));
		send_frame(3, 1'b1);
		random_traffic(80);
		settle();

		// random marker, back-to-back bytes
		tx_no_gap = 1'b1;
		configure({$urandom, $urandom}, 8'd0);
		send_header(cur_marker);
		random_traffic(80);
		settle();

		// all-ones marker, sink never stalls
		tx_no_gap   = 1'b0;
		ev_no_stall = 1'b1;
		configure('1, 8'd128);
		random_traffic(80);
		// huge length: the body runs far past the end of the stimulus
		send_header(64'h0100_0000_0000_0005);
		put_byte(next_seq);
		repeat (40) put_byte(8'($urandom));
		settle();

		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> filelist.f
sv/lpd_pkg.sv
sv/lpd_rx_if.sv
sv/lpd_ev_if.sv
sv/lpd_cfg.sv
sv/lpd_core.sv
sv/length_prefixed_deframer.sv
sv/lpd_checker.sv
tb/lpd_event_checker.sv
tb/testbench.sv
